// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers for the soma area rtl, included by sas_seq
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SAS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sas_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_pkg
// Types, widths and constants of the soma surface area unit.
// ---------------------------------------------------------------------------
package sas_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int POS_W    = 32;
  localparam int DIA_W    = 32;
  localparam int KIND_W   = 3;
  localparam int AREA_W   = 48;
  localparam int STAT_W   = 3;

  // shared multiplier operands, product and accumulator
  localparam int OPW      = 34;
  localparam int PROD_W   = 2 * OPW;
  localparam int ACC_W    = 104;

  // root unit: radicand and root widths
  localparam int RAD_W    = PROD_W;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;

  // pi in Q2.32, rounded
  localparam int PI_FRAC  = 32;
  localparam logic [OPW-1:0] PI_Q = 34'h3_243F_6A89;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_UNDEF   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_THREE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CYL     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CONTOUR = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_SINGLE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_THREE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_CONTOUR    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_UNDEF      = 3'd4;

  localparam int NEED_SINGLE = 1;
  localparam int NEED_THREE  = 3;
  localparam int MIN_CYL     = 2;

  typedef enum logic [1:0] {
    SH_0,
    SH_2,
    SH_34
  } sh_t;

  typedef struct packed {
    logic issue;
    logic clr;
    sh_t  sh;
  } mac_cmd_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic [STAT_W-1:0] status;
    logic              sat;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIFF,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_D,
    S_WAIT_N,
    S_SQRT_GO,
    S_SQRT,
    S_MUL_P,
    S_WAIT_P,
    S_SQ_R,
    S_WAIT_R,
    S_LATCH,
    S_PI_LO,
    S_PI_HI,
    S_WAIT_Q,
    S_ROUND,
    S_ACCUM,
    S_POST,
    S_EMIT
  } state_t;

endpackage

// File: rtl/core/sas_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_mac
// Shared multiply-accumulate unit: registered 34x34 product, then a shifted
// add into a wide accumulator on the following cycle.
// ---------------------------------------------------------------------------
module sas_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sas_pkg::mac_cmd_t         cmd,
  input  logic [sas_pkg::OPW-1:0]   op_a,
  input  logic [sas_pkg::OPW-1:0]   op_b,
  output logic [sas_pkg::ACC_W-1:0] acc
);
  import sas_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              v_r;
  logic              clr_r;
  sh_t               sh_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  addend;

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (sh_r)
      SH_0:    addend = prod_ext;
      SH_2:    addend = prod_ext << 2;
      SH_34:   addend = prod_ext << OPW;
      default: addend = prod_ext;
    endcase
    acc_nxt = (clr_r ? '0 : acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
    clr_r  <= cmd.clr;
    sh_r   <= cmd.sh;
    if (v_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// File: rtl/core/sas_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sas_sqrt
// Integer square root, restoring digit by digit, one root bit per cycle.
// ---------------------------------------------------------------------------
module sas_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sas_pkg::RAD_W-1:0]  rad,
  output logic                       done,
  output logic [sas_pkg::ROOT_W-1:0] root
);
  import sas_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/core/sas_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// sas_seq
// Sequencer and soma state: drives the shared multiplier and the root unit
// through the frustum and sphere formulae, keeps the running sum.
// ---------------------------------------------------------------------------
module sas_seq #(
  parameter int COUNT_WIDTH = sas_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = sas_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sas_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [sas_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [sas_pkg::POS_W-1:0]  in_pos_z,
  input  logic [sas_pkg::DIA_W-1:0]         in_diameter,
  input  logic                              in_last_sample,
  input  logic [sas_pkg::KIND_W-1:0]        kind,
  output logic                              res_valid,
  output sas_pkg::res_t                     res,
  input  logic                              res_ready,
  output sas_pkg::mac_cmd_t                 mac_cmd,
  output logic [sas_pkg::OPW-1:0]           mac_a,
  output logic [sas_pkg::OPW-1:0]           mac_b,
  input  logic [sas_pkg::ACC_W-1:0]         mac_acc,
  output logic                              sqrt_start,
  output logic [sas_pkg::RAD_W-1:0]         sqrt_rad,
  input  logic                              sqrt_done,
  input  logic [sas_pkg::ROOT_W-1:0]        sqrt_root
);
  import sas_pkg::*;

  // diameters carry one extra fraction bit against radii, hence the extra 2
  localparam int SEG_SH = PI_FRAC + 2 + FRAC_BITS;
  localparam int SPH_SH = PI_FRAC + FRAC_BITS;
  localparam logic [ACC_W-1:0] ONE_ACC  = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic [ACC_W-1:0] HALF_SEG = ONE_ACC << (SEG_SH - 1);
  localparam logic [ACC_W-1:0] HALF_SPH = ONE_ACC << (SPH_SH - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  function automatic logic [POS_W-1:0] abs_sdiff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    logic [POS_W:0] n;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    n = ~d + 1'b1;
    return d[POS_W] ? n[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  function automatic logic [DIA_W-1:0] abs_udiff(input logic [DIA_W-1:0] a,
                                                 input logic [DIA_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  state_t state_r;
  state_t state_nxt;

  logic [POS_W-1:0]       x_r, y_r, z_r;
  logic [DIA_W-1:0]       dia_r;
  logic                   last_r;
  logic [POS_W-1:0]       px_r, py_r, pz_r;
  logic [DIA_W-1:0]       pd_r;
  logic [DIA_W-1:0]       first_r;
  logic [POS_W-1:0]       mx_r, my_r, mz_r;
  logic [DIA_W-1:0]       md_r;
  logic [DIA_W:0]         sumd_r;
  logic [PROD_W-1:0]      op_r;
  logic                   sph_r;
  logic [AREA_W-1:0]      term_r;
  logic                   tsat_r;
  res_t                   res_r;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_inc;
  logic [AREA_W-1:0]      area_sum_r, area_sum_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [AREA_W:0]        sum_wide;
  logic                   sum_ovf;
  logic [ACC_W-1:0]       rnd;
  logic [ACC_W-1:0]       rnd_sh;
  logic                   rsat;
  logic [AREA_W-1:0]      rterm;
  logic                   sphere_go;
  res_t                   post_res;
  logic                   first_smp;

  assign first_smp = (count_r == '0);
  assign count_inc = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;

  // rounding of the pi-scaled product
  always_comb begin
    rnd    = mac_acc + (sph_r ? HALF_SPH : HALF_SEG);
    rnd_sh = sph_r ? (rnd >> SPH_SH) : (rnd >> SEG_SH);
    rsat   = |rnd_sh[ACC_W-1:AREA_W];
    rterm  = rsat ? AREA_MAX : rnd_sh[AREA_W-1:0];
  end

  always_comb begin
    sum_wide = {1'b0, area_sum_r} + {1'b0, term_r};
    sum_ovf  = tsat_r | sum_wide[AREA_W];
  end

  // result once the closing sample is in
  always_comb begin
    sphere_go = 1'b0;
    post_res  = '{area: '0, status: STAT_OK, sat: 1'b0};
    case (kind)
      KIND_SINGLE: begin
        if (count_inc == COUNT_WIDTH'(NEED_SINGLE)) begin
          sphere_go = 1'b1;
        end else begin
          post_res.status = STAT_BAD_SINGLE;
        end
      end
      KIND_THREE: begin
        if (count_inc == COUNT_WIDTH'(NEED_THREE)) begin
          sphere_go = 1'b1;
        end else begin
          post_res.status = STAT_BAD_THREE;
        end
      end
      KIND_CYL: begin
        if (count_inc >= COUNT_WIDTH'(MIN_CYL)) begin
          post_res.area = area_sum_r;
          post_res.sat  = ovf_r;
        end
      end
      KIND_CONTOUR: post_res.status = STAT_CONTOUR;
      default:      post_res.status = STAT_UNDEF;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DIFF;
      S_DIFF:    state_nxt = first_smp ? S_POST : S_SQ_X;
      S_SQ_X:    state_nxt = S_SQ_Y;
      S_SQ_Y:    state_nxt = S_SQ_Z;
      S_SQ_Z:    state_nxt = S_SQ_D;
      S_SQ_D:    state_nxt = S_WAIT_N;
      S_WAIT_N:  state_nxt = S_SQRT_GO;
      S_SQRT_GO: state_nxt = S_SQRT;
      S_SQRT:    if (sqrt_done) state_nxt = S_MUL_P;
      S_MUL_P:   state_nxt = S_WAIT_P;
      S_WAIT_P:  state_nxt = S_LATCH;
      S_SQ_R:    state_nxt = S_WAIT_R;
      S_WAIT_R:  state_nxt = S_LATCH;
      S_LATCH:   state_nxt = S_PI_LO;
      S_PI_LO:   state_nxt = S_PI_HI;
      S_PI_HI:   state_nxt = S_WAIT_Q;
      S_WAIT_Q:  state_nxt = S_ROUND;
      S_ROUND:   state_nxt = sph_r ? S_EMIT : S_ACCUM;
      S_ACCUM:   state_nxt = S_POST;
      S_POST: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (sphere_go) begin
          state_nxt = S_SQ_R;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT:    if (res_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    sqrt_start = 1'b0;
    mac_cmd    = '{issue: 1'b0, clr: 1'b0, sh: SH_0};
    mac_a      = '0;
    mac_b      = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SQ_X: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b1, sh: SH_2};
        mac_a   = OPW'(mx_r);
        mac_b   = OPW'(mx_r);
      end
      S_SQ_Y: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b0, sh: SH_2};
        mac_a   = OPW'(my_r);
        mac_b   = OPW'(my_r);
      end
      S_SQ_Z: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b0, sh: SH_2};
        mac_a   = OPW'(mz_r);
        mac_b   = OPW'(mz_r);
      end
      S_SQ_D: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b0, sh: SH_0};
        mac_a   = OPW'(md_r);
        mac_b   = OPW'(md_r);
      end
      S_SQRT_GO: sqrt_start = 1'b1;
      S_MUL_P: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = OPW'(sumd_r);
        mac_b   = sqrt_root;
      end
      S_SQ_R: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = OPW'(first_r);
        mac_b   = OPW'(first_r);
      end
      S_PI_LO: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = op_r[OPW-1:0];
        mac_b   = PI_Q;
      end
      S_PI_HI: begin
        mac_cmd = '{issue: 1'b1, clr: 1'b0, sh: SH_34};
        mac_a   = op_r[PROD_W-1:OPW];
        mac_b   = PI_Q;
      end
      S_EMIT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign sqrt_rad = mac_acc[RAD_W-1:0];
  assign res      = res_r;

  // soma state
  always_comb begin
    count_nxt    = count_r;
    area_sum_nxt = area_sum_r;
    ovf_nxt      = ovf_r;
    case (state_r)
      S_ACCUM: begin
        area_sum_nxt = sum_ovf ? AREA_MAX : sum_wide[AREA_W-1:0];
        ovf_nxt      = ovf_r | sum_ovf;
      end
      S_POST: count_nxt = count_inc;
      S_EMIT: begin
        if (res_ready) begin
          count_nxt    = '0;
          area_sum_nxt = '0;
          ovf_nxt      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      area_sum_r <= '0;
      ovf_r      <= 1'b0;
      sph_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      area_sum_r <= area_sum_nxt;
      ovf_r      <= ovf_nxt;
      if (state_r == S_DIFF) begin
        sph_r <= 1'b0;
      end else if (state_r == S_POST) begin
        sph_r <= sphere_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      z_r    <= in_pos_z;
      dia_r  <= in_diameter;
      last_r <= in_last_sample;
    end
    case (state_r)
      S_DIFF: begin
        mx_r   <= abs_sdiff(x_r, px_r);
        my_r   <= abs_sdiff(y_r, py_r);
        mz_r   <= abs_sdiff(z_r, pz_r);
        md_r   <= abs_udiff(dia_r, pd_r);
        sumd_r <= {1'b0, dia_r} + {1'b0, pd_r};
        if (first_smp) begin
          first_r <= dia_r;
        end
      end
      S_LATCH: op_r <= mac_acc[PROD_W-1:0];
      S_ROUND: begin
        term_r <= rterm;
        tsat_r <= rsat;
        if (sph_r) begin
          res_r <= '{area: rterm, status: STAT_OK, sat: rsat};
        end
      end
      S_POST: begin
        px_r  <= x_r;
        py_r  <= y_r;
        pz_r  <= z_r;
        pd_r  <= dia_r;
        res_r <= post_res;
      end
      default: ;
    endcase
  end

  `SAS_ASSERT_NXT(a_accept_starts_diff, in_valid && in_ready, state_r == S_DIFF,
    "accepted beat did not start a sample")
  `SAS_ASSERT_IMP(a_root_done_waited, sqrt_done, state_r == S_SQRT,
    "root finished while the sequencer was not waiting for it")
  `SAS_ASSERT_IMP(a_ovf_pins_sum, ovf_r, area_sum_r == AREA_MAX,
    "overflow flag set with an unclamped sum")
  `SAS_ASSERT_IMP(a_empty_soma_clear, count_r == '0, area_sum_r == '0 && !ovf_r,
    "empty soma holds a stale sum")

endmodule

// File: rtl/core/soma_surface_area_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// soma_surface_area_unit
// Surface area of a soma streamed as samples: sphere area for single and
// three-point somata, summed frustum side areas for cylinder somata.
// ---------------------------------------------------------------------------
//  port group | direction | handshake          | beat carries
//  in_        | input     | in_valid/in_ready  | pos x/y/z, diameter, last mark
//  out_       | output    | out_valid/out_ready| area Q32.16, status, saturated
//  cfg_       | input     | cfg_valid/cfg_ready| soma kind
//
//  first sample of a soma: no area term; every later sample uses the
//  one-bit-per-cycle root unit, the shared 34x34 multiplier steps and
//  rounding.
//  closing a single or three-point soma adds a sphere area pass.
//  reset is synchronous; no clearing pass, ready straight out of reset.
//  a result waiting in the output register does not block intake; only a
//  soma close stalls until that register is free.
// ---------------------------------------------------------------------------
module soma_surface_area_unit #(
  parameter int COUNT_WIDTH = sas_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = sas_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sas_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [sas_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [sas_pkg::POS_W-1:0] in_pos_z,
  input  logic [sas_pkg::DIA_W-1:0]        in_diameter,
  input  logic                             in_last_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sas_pkg::AREA_W-1:0]       out_surface_area,
  output logic [sas_pkg::STAT_W-1:0]       out_status,
  output logic                             out_saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sas_pkg::KIND_W-1:0]       cfg_soma_kind
);
  import sas_pkg::*;

  logic [KIND_W-1:0] kind_r;
  logic              out_valid_r;
  logic [AREA_W-1:0] area_r;
  logic [STAT_W-1:0] status_r;
  logic              sat_r;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  mac_cmd_t          mac_cmd;
  logic [OPW-1:0]    mac_a;
  logic [OPW-1:0]    mac_b;
  logic [ACC_W-1:0]  mac_acc;
  logic              sqrt_start;
  logic [RAD_W-1:0]  sqrt_rad;
  logic              sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  sas_seq #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_diameter    (in_diameter),
    .in_last_sample (in_last_sample),
    .kind           (kind_r),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .mac_cmd        (mac_cmd),
    .mac_a          (mac_a),
    .mac_b          (mac_b),
    .mac_acc        (mac_acc),
    .sqrt_start     (sqrt_start),
    .sqrt_rad       (sqrt_rad),
    .sqrt_done      (sqrt_done),
    .sqrt_root      (sqrt_root)
  );

  sas_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mac_cmd),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  sas_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (sqrt_rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // output register frees as its beat leaves
  assign res_ready = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_UNDEF;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        kind_r <= cfg_soma_kind;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      area_r   <= res.area;
      status_r <= res.status;
      sat_r    <= res.sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_surface_area = area_r;
  assign out_status       = status_r;
  assign out_saturated    = sat_r;

endmodule
